[rtl/edf_priority_queue_unit_defines.svh]
// assertion macros for the edf priority queue unit
`ifndef EDF_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define EDF_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define EDFPQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("edfpq check failed");
`define EDFPQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edfpq check failed");
`define EDFPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edfpq check failed");
`else
`define EDFPQ_ASSERT_ALWAYS(lbl, cond)
`define EDFPQ_ASSERT_SAME(lbl, ante, cons)
`define EDFPQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/edfpq_pkg.sv]
package edfpq_pkg;

  localparam int ID_W = 8;
  localparam int DL_W = 48;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic            opcode;
    logic [ID_W-1:0] task_id;
    logic [DL_W-1:0] deadline;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            head_valid;
    logic [ID_W-1:0] head_id;
    logic [DL_W-1:0] head_deadline;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] deadline;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_HEAD_RD,
    ST_RESP
  } state_t;

endpackage

[rtl/edfpq_ram.sv]
module edfpq_ram #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  edfpq_pkg::entry_t        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output edfpq_pkg::entry_t        rdata
);

  edfpq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/edf_priority_queue_unit.sv]
// Earliest-deadline-first task queue holding up to DEPTH tasks in one
// single-port-read, single-port-write RAM, kept sorted with the head in slot 0.
// Pulse start with cmd while busy is low; busy then stays high until the
// result beat, which appears on result for exactly one cycle with done high
// and cannot be stalled. The walk reads one RAM entry per cycle and shifts
// entries with a read-ahead, then an add writes the tail, and the head is
// read back through ST_HEAD_RD and ST_RESP. A full add or a finish on an
// empty queue skips the walk and goes straight to the head read; an add to
// an empty queue skips it and goes to the tail write. No clearing pass after
// reset: only data from occupied slots is used.
`include "edf_priority_queue_unit_defines.svh"

module edf_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  edfpq_pkg::cmd_t   cmd,
  output logic              busy,
  output logic              done,
  output edfpq_pkg::rsp_t   result
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  edfpq_pkg::state_t state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [IW-1:0]     k, k_next;
  logic              found, found_next;
  logic              op, op_next;
  logic [1:0]        status, status_next;
  edfpq_pkg::entry_t carry, carry_next;
  logic              done_next;
  edfpq_pkg::rsp_t   result_next;

  logic              we;
  logic [IW-1:0]     waddr;
  edfpq_pkg::entry_t wdata;
  logic [IW-1:0]     raddr;
  edfpq_pkg::entry_t rdata;

  logic last;
  logic goes_before;
  logic id_match;

  edfpq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign last        = (CW'(k) + CW'(1)) == count;
  assign goes_before = (rdata.deadline > carry.deadline) ||
                       ((rdata.deadline == carry.deadline) && (rdata.id < carry.id));
  assign id_match    = rdata.id == carry.id;
  assign busy        = state != edfpq_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edfpq_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    k      <= k_next;
    found  <= found_next;
    op     <= op_next;
    status <= status_next;
    carry  <= carry_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    k_next      = k;
    found_next  = found;
    op_next     = op;
    status_next = status;
    carry_next  = carry;
    done_next   = 1'b0;
    result_next = result;
    we          = 1'b0;
    waddr       = k;
    wdata       = carry;
    raddr       = '0;

    case (state)
      edfpq_pkg::ST_IDLE: begin
        if (start) begin
          op_next     = cmd.opcode;
          carry_next  = '{id: cmd.task_id, deadline: cmd.deadline};
          k_next      = '0;
          found_next  = 1'b0;
          status_next = edfpq_pkg::STATUS_OK;
          if (cmd.opcode == edfpq_pkg::OP_ADD && count == CW'(DEPTH)) begin
            status_next = edfpq_pkg::STATUS_FULL;
            state_next  = edfpq_pkg::ST_HEAD_RD;
          end else if (count == '0) begin
            if (cmd.opcode == edfpq_pkg::OP_ADD) begin
              state_next = edfpq_pkg::ST_TAIL;
            end else begin
              status_next = edfpq_pkg::STATUS_NOT_FOUND;
              state_next  = edfpq_pkg::ST_HEAD_RD;
            end
          end else begin
            state_next = edfpq_pkg::ST_SCAN;
          end
        end
      end

      edfpq_pkg::ST_SCAN: begin
        // rdata holds slot k; read ahead to slot k+1
        if (!last) begin
          raddr = k + IW'(1);
        end
        if (op == edfpq_pkg::OP_ADD) begin
          // once the insertion point is passed, ripple the carried entry down
          if (found || goes_before) begin
            we         = 1'b1;
            waddr      = k;
            wdata      = carry;
            carry_next = rdata;
            found_next = 1'b1;
          end
        end else begin
          if (found) begin
            we    = 1'b1;
            waddr = k - IW'(1);
            wdata = rdata;
          end else if (id_match) begin
            found_next = 1'b1;
          end
        end
        if (last) begin
          if (op == edfpq_pkg::OP_ADD) begin
            state_next = edfpq_pkg::ST_TAIL;
          end else begin
            if (found || id_match) begin
              count_next = count - CW'(1);
            end else begin
              status_next = edfpq_pkg::STATUS_NOT_FOUND;
            end
            state_next = edfpq_pkg::ST_HEAD_RD;
          end
        end else begin
          k_next = k + IW'(1);
        end
      end

      edfpq_pkg::ST_TAIL: begin
        we         = 1'b1;
        waddr      = count[IW-1:0];
        wdata      = carry;
        count_next = count + CW'(1);
        state_next = edfpq_pkg::ST_HEAD_RD;
      end

      edfpq_pkg::ST_HEAD_RD: begin
        raddr      = '0;
        state_next = edfpq_pkg::ST_RESP;
      end

      edfpq_pkg::ST_RESP: begin
        done_next          = 1'b1;
        result_next.status = status;
        if (count != '0) begin
          result_next.head_valid    = 1'b1;
          result_next.head_id       = rdata.id;
          result_next.head_deadline = rdata.deadline;
        end else begin
          result_next.head_valid    = 1'b0;
          result_next.head_id       = '0;
          result_next.head_deadline = '0;
        end
        state_next = edfpq_pkg::ST_IDLE;
      end

      default: begin
        state_next = edfpq_pkg::ST_IDLE;
      end
    endcase
  end

  `EDFPQ_ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH))
  `EDFPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `EDFPQ_ASSERT_NEXT(a_done_single, done, !done)
  `EDFPQ_ASSERT_SAME(a_head_valid, done, result.head_valid == (count != '0))

endmodule
